@@ design/a64ps_pkg.sv @@
// Shared types and decode constants for the A64 prologue scanner.
`default_nettype none

package a64ps_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned REG_W   = 5;
    localparam int unsigned CNT_W   = 5;
    localparam int unsigned PAIR_W  = 7;
    localparam int unsigned HALF_W  = 40;
    localparam int unsigned FRAME_W = 18;
    localparam int unsigned SLOTS   = 16;
    localparam int unsigned OUT_W   = 120;

    localparam logic [31:0] STP_MASK    = 32'hffc0_0000;
    localparam logic [31:0] STP_OFFSET  = 32'ha900_0000;
    localparam logic [31:0] STP_PREIDX  = 32'ha980_0000;
    localparam logic [31:0] SUB_MASK    = 32'hff80_0000;
    localparam logic [31:0] SUB_IMM     = 32'hd100_0000;
    localparam logic [31:0] SUB_ALT     = 32'hd380_0000;
    localparam logic [31:0] PAC_HINT_A  = 32'hd503_233f;
    localparam logic [31:0] PAC_HINT_B  = 32'hd503_235f;
    localparam logic [31:0] BIMM_MASK   = 32'hfc00_0000;
    localparam logic [31:0] B_CODE      = 32'h1400_0000;
    localparam logic [31:0] BL_CODE     = 32'h9400_0000;
    localparam logic [31:0] BREG_MASK   = 32'hffff_fc1f;
    localparam logic [31:0] BR_CODE     = 32'hd61f_0000;
    localparam logic [31:0] RET_CODE    = 32'hd65f_0000;

    localparam logic [REG_W-1:0]  REG_SP  = 5'd31;
    localparam logic [REG_W-1:0]  REG_FP  = 5'd29;
    localparam logic [REG_W-1:0]  REG_LR  = 5'd30;
    localparam logic [PAIR_W-1:0] PAIR_MAX = 7'd127;

    // Fields pulled out of one instruction word
    typedef struct packed {
        logic               is_pair;
        logic [REG_W-1:0]   rt;
        logic [REG_W-1:0]   rt2;
        logic               is_frame_sub;
        logic [FRAME_W-1:0] frame_bytes;
        logic               is_pac;
        logic               is_branch;
    } decode_t;

    // Frame summary for one sequence
    typedef struct packed {
        logic               fp_saved;
        logic               lr_saved;
        logic               pac_seen;
        logic [PAIR_W-1:0]  pair_total;
        logic [CNT_W-1:0]   list_count;
        logic [HALF_W-1:0]  list_low;
        logic [HALF_W-1:0]  list_high;
        logic [FRAME_W-1:0] frame_bytes;
    } summary_t;

endpackage

`default_nettype wire

@@ design/a64_prologue_scanner.sv @@
// A64 prologue scanner: takes instruction words on s_*, gives one frame summary per
// sequence on m_*.
//
// Input channel s_*: one 32-bit instruction word per item in s_tdata, s_tlast set on
// the final word of a function's sequence. Words after a branch, return or the scan
// limit are taken and ignored until the tlast item.
// Output channel m_*: one summary item per sequence, sent for the tlast input item.
// Timing: a word is held in the input register and decoded into the running state
// when it is consumed; the summary is registered in the result register as the tlast
// item is consumed, and m_tvalid is driven from that register.
// Throughput: one word per cycle; the decode and state update is a single registered
// pass, so a word can be taken every clock unless a tlast word waits for room.
// Stall: while m_tready is low and a summary waits, words that are not tlast keep
// flowing; a second tlast item holds in the input register, and s_tready drops only
// then.
// Reset: clears the scan flags and counters and both valid flags; the first item after
// reset starts a new sequence.
`default_nettype none

module a64_prologue_scanner #(
    parameter int unsigned MAX_SCAN_WORDS = 32,
    parameter int unsigned LIST_DEPTH     = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [31:0]  s_tdata,   // [31:0] insn_word
    input  wire logic         s_tlast,   // last_in_sequence
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [119:0]      m_tdata    // [0] frame_pointer_saved, [1] link_saved,
                                         // [2] pac_seen, [9:3] pair_reg_total,
                                         // [14:10] list_count, [54:15] list_low_half,
                                         // [94:55] list_high_half,
                                         // [112:95] stack_frame_bytes, [119:113] zero
);

    logic                   in_valid_reg;
    logic [31:0]            in_word_reg;
    logic                   in_last_reg;
    logic                   out_valid_reg, out_valid_next;
    logic [119:0]           out_data_reg;
    logic                   out_free;
    logic                   consume;
    a64ps_pkg::decode_t     dec;
    a64ps_pkg::summary_t    summary;

    assign out_free = !out_valid_reg || m_tready;
    // A tlast word needs room in the result register; other words always proceed
    assign consume  = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || consume;

    a64ps_decode u_decode (
        .word (in_word_reg),
        .dec  (dec)
    );

    a64ps_frame #(
        .MAX_SCAN_WORDS (MAX_SCAN_WORDS),
        .LIST_DEPTH     (LIST_DEPTH)
    ) u_frame (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (consume),
        .last    (in_last_reg),
        .dec     (dec),
        .summary (summary)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (consume && in_last_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_word_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (consume && in_last_reg)
        begin
            out_data_reg <= {7'd0,
                             summary.frame_bytes,
                             summary.list_high,
                             summary.list_low,
                             summary.list_count,
                             summary.pair_total,
                             summary.pac_seen,
                             summary.lr_saved,
                             summary.fp_saved};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

@@ design/a64ps_decode.sv @@
// Instruction word decoder: store-pair, frame subtract, pac hint and branch classes.
`default_nettype none

module a64ps_decode (
    input  wire logic [31:0]      word,
    output a64ps_pkg::decode_t    dec
);

    logic [31:0] top10;
    logic [31:0] top9;
    logic [17:0] imm_ext;
    logic [1:0]  sh;

    assign top10   = word & a64ps_pkg::STP_MASK;
    assign top9    = word & a64ps_pkg::SUB_MASK;
    assign imm_ext = {6'd0, word[21:10]};
    assign sh      = word[23:22];

    always_comb
    begin
        dec.is_pair = (top10 == a64ps_pkg::STP_OFFSET) || (top10 == a64ps_pkg::STP_PREIDX);
        dec.rt      = word[4:0];
        dec.rt2     = word[14:10];
        dec.is_frame_sub = ((top9 == a64ps_pkg::SUB_IMM) || (top9 == a64ps_pkg::SUB_ALT))
                           && (word[4:0] == a64ps_pkg::REG_SP);
        // imm12 scaled by 1, 4, 16 or 64
        case (sh)
            2'd0:    dec.frame_bytes = imm_ext;
            2'd1:    dec.frame_bytes = imm_ext << 2;
            2'd2:    dec.frame_bytes = imm_ext << 4;
            default: dec.frame_bytes = imm_ext << 6;
        endcase
        dec.is_pac = (word == a64ps_pkg::PAC_HINT_A) || (word == a64ps_pkg::PAC_HINT_B);
        dec.is_branch = ((word & a64ps_pkg::BIMM_MASK) == a64ps_pkg::B_CODE)
                     || ((word & a64ps_pkg::BIMM_MASK) == a64ps_pkg::BL_CODE)
                     || ((word & a64ps_pkg::BREG_MASK) == a64ps_pkg::BR_CODE)
                     || ((word & a64ps_pkg::BREG_MASK) == a64ps_pkg::RET_CODE);
    end

endmodule

`default_nettype wire

@@ design/a64ps_frame.sv @@
// Running frame state: flags, pair count, save list, frame size and scan limit.
`default_nettype none

module a64ps_frame #(
    parameter int unsigned MAX_SCAN_WORDS = 32,
    parameter int unsigned LIST_DEPTH     = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step,
    input  wire logic                last,
    input  a64ps_pkg::decode_t       dec,
    output a64ps_pkg::summary_t      summary
);

    localparam int unsigned IDX_W = $clog2(MAX_SCAN_WORDS + 1);

    logic                                fp_reg, fp_next;
    logic                                lr_reg, lr_next;
    logic                                pac_reg, pac_next;
    logic [a64ps_pkg::PAIR_W-1:0]        pair_reg, pair_next;
    logic [a64ps_pkg::CNT_W-1:0]         count_reg, count_next;
    logic [a64ps_pkg::FRAME_W-1:0]       frame_reg, frame_next;
    logic [IDX_W-1:0]                    index_reg, index_next;
    logic                                stopped_reg, stopped_next;
    logic [a64ps_pkg::REG_W-1:0]         list_reg  [LIST_DEPTH];
    logic [a64ps_pkg::REG_W-1:0]         list_next [LIST_DEPTH];
    logic [a64ps_pkg::REG_W-1:0]         slot      [a64ps_pkg::SLOTS];

    logic                                active;
    logic                                pair_hit;
    logic                                push1;
    logic                                push2;
    logic [a64ps_pkg::CNT_W-1:0]         count_p1;
    logic [a64ps_pkg::PAIR_W:0]          pair_sum;

    assign active   = !stopped_reg && (index_reg < IDX_W'(MAX_SCAN_WORDS));
    assign pair_hit = active && dec.is_pair;
    assign count_p1 = count_reg + a64ps_pkg::CNT_W'(1);
    assign push1    = pair_hit && (count_reg < a64ps_pkg::CNT_W'(LIST_DEPTH));
    assign push2    = push1 && (dec.rt != dec.rt2)
                      && (count_p1 < a64ps_pkg::CNT_W'(LIST_DEPTH));
    assign pair_sum = {1'b0, pair_reg} + (a64ps_pkg::PAIR_W + 1)'(2);

    always_comb
    begin
        fp_next      = fp_reg;
        lr_next      = lr_reg;
        pac_next     = pac_reg;
        pair_next    = pair_reg;
        frame_next   = frame_reg;
        index_next   = index_reg;
        stopped_next = stopped_reg;
        count_next   = count_reg + a64ps_pkg::CNT_W'(push1) + a64ps_pkg::CNT_W'(push2);
        if (pair_hit)
        begin
            if (dec.rt == a64ps_pkg::REG_FP || dec.rt == a64ps_pkg::REG_LR)
            begin
                fp_next = 1'b1;
            end
            if (dec.rt == a64ps_pkg::REG_LR || dec.rt2 == a64ps_pkg::REG_LR)
            begin
                lr_next = 1'b1;
            end
            pair_next = (pair_sum > {1'b0, a64ps_pkg::PAIR_MAX}) ? a64ps_pkg::PAIR_MAX
                                                                  : pair_sum[a64ps_pkg::PAIR_W-1:0];
        end
        if (active)
        begin
            if (dec.is_frame_sub)
            begin
                frame_next = dec.frame_bytes;
            end
            if (dec.is_pac)
            begin
                pac_next = 1'b1;
            end
            if (dec.is_branch)
            begin
                stopped_next = 1'b1;
            end
            index_next = index_reg + IDX_W'(1);
        end
    end

    always_comb
    begin
        for (int k = 0; k < LIST_DEPTH; k++)
        begin
            list_next[k] = list_reg[k];
            if (push1 && count_reg == a64ps_pkg::CNT_W'(k))
            begin
                list_next[k] = dec.rt;
            end
            if (push2 && count_p1 == a64ps_pkg::CNT_W'(k))
            begin
                list_next[k] = dec.rt2;
            end
        end
    end

    // Slots past the fill count or the list depth read as zero
    for (genvar g = 0; g < a64ps_pkg::SLOTS; g++)
    begin : g_slot
        if (g < LIST_DEPTH)
        begin : g_live
            assign slot[g] = (a64ps_pkg::CNT_W'(g) < count_next) ? list_next[g]
                                                                 : '0;
        end
        else
        begin : g_none
            assign slot[g] = '0;
        end
    end

    always_comb
    begin
        summary.fp_saved    = fp_next;
        summary.lr_saved    = lr_next;
        summary.pac_seen    = pac_next;
        summary.pair_total  = pair_next;
        summary.list_count  = count_next;
        summary.frame_bytes = frame_next;
        summary.list_low    = '0;
        summary.list_high   = '0;
        for (int k = 0; k < 8; k++)
        begin
            summary.list_low[5*k +: 5]  = slot[k];
            summary.list_high[5*k +: 5] = slot[k+8];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fp_reg      <= 1'b0;
            lr_reg      <= 1'b0;
            pac_reg     <= 1'b0;
            pair_reg    <= '0;
            count_reg   <= '0;
            frame_reg   <= '0;
            index_reg   <= '0;
            stopped_reg <= 1'b0;
        end
        else if (step)
        begin
            if (last)
            begin
                fp_reg      <= 1'b0;
                lr_reg      <= 1'b0;
                pac_reg     <= 1'b0;
                pair_reg    <= '0;
                count_reg   <= '0;
                frame_reg   <= '0;
                index_reg   <= '0;
                stopped_reg <= 1'b0;
            end
            else
            begin
                fp_reg      <= fp_next;
                lr_reg      <= lr_next;
                pac_reg     <= pac_next;
                pair_reg    <= pair_next;
                count_reg   <= count_next;
                frame_reg   <= frame_next;
                index_reg   <= index_next;
                stopped_reg <= stopped_next;
            end
        end
    end

    // List contents are payload; the fill count says which entries hold data
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            for (int k = 0; k < LIST_DEPTH; k++)
            begin
                list_reg[k] <= list_next[k];
            end
        end
    end

endmodule

`default_nettype wire

@@ tb/sv/tb_a64_prologue_scanner.sv @@
// Self-checking testbench for the A64 prologue scanner: directed table plus random prologues.
`timescale 1ns / 1ps

module tb_a64_prologue_scanner;

    localparam int unsigned RANDOM_WORDS = 1200;
    localparam int unsigned CYCLE_LIMIT  = 300000;
    localparam int unsigned SCAN_LIMIT   = 32;

    typedef enum
    {
        W_PAIR,
        W_SUB,
        W_PAC,
        W_BRANCH,
        W_NEAR,
        W_NOISE
    } word_kind_t;

    typedef struct
    {
        logic [31:0]         word;
        logic                last;
        bit                  typed;
        a64ps_pkg::summary_t want;
    } stim_row_t;

    localparam a64ps_pkg::summary_t MAX_FRAME_SUMMARY =
        '{1'b0, 1'b0, 1'b0, 7'd0, 5'd0, 40'd0, 40'd0, 18'd262080};

    logic          clk;
    logic          rst_n;
    logic          s_tvalid;
    logic          s_tready;
    logic [31:0]   s_tdata;
    logic          s_tlast;
    logic          m_tvalid;
    logic          m_tready;
    logic [119:0]  m_tdata;

    // running frame summary as the scanner should hold it
    logic          trk_fp;
    logic          trk_lr;
    logic          trk_pac;
    logic          trk_stop;
    logic [6:0]    trk_pairs;
    logic [4:0]    trk_count;
    logic [4:0]    trk_list [a64ps_pkg::SLOTS];
    logic [17:0]   trk_frame;
    int unsigned   trk_index;

    a64ps_pkg::summary_t summary_q [$];
    stim_row_t     directed_rows [$];
    int unsigned   sent_words;
    int unsigned   mismatches;
    int unsigned   cycles;
    bit            quiet;

    a64_prologue_scanner i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("a64_prologue_scanner test failed");
            $finish;
        end
    end

    task automatic clear_track();
        trk_fp    = 1'b0;
        trk_lr    = 1'b0;
        trk_pac   = 1'b0;
        trk_stop  = 1'b0;
        trk_pairs = '0;
        trk_count = '0;
        trk_frame = '0;
        trk_index = 0;
    endtask

    // Fold one accepted word into the running summary; emit and clear on the last word.
    task automatic track_word(input logic [31:0] w, input logic last,
                              output a64ps_pkg::summary_t s, output bit emits);
        logic [4:0]  rt;
        logic [4:0]  rt2;
        logic [31:0] shifted;
        int          k;
        if (!trk_stop && trk_index < SCAN_LIMIT)
        begin
            trk_index++;
            if ((w & a64ps_pkg::STP_MASK) == a64ps_pkg::STP_OFFSET ||
                (w & a64ps_pkg::STP_MASK) == a64ps_pkg::STP_PREIDX)
            begin
                rt  = w[4:0];
                rt2 = w[14:10];
                if (rt == a64ps_pkg::REG_FP || rt == a64ps_pkg::REG_LR)
                    trk_fp = 1'b1;
                if (rt == a64ps_pkg::REG_LR || rt2 == a64ps_pkg::REG_LR)
                    trk_lr = 1'b1;
                if (trk_count < a64ps_pkg::SLOTS)
                begin
                    trk_list[trk_count[3:0]] = rt;
                    trk_count++;
                end
                if (rt != rt2 && trk_count < a64ps_pkg::SLOTS)
                begin
                    trk_list[trk_count[3:0]] = rt2;
                    trk_count++;
                end
                trk_pairs = (trk_pairs > a64ps_pkg::PAIR_MAX - 7'd2) ? a64ps_pkg::PAIR_MAX
                                                                       : trk_pairs + 7'd2;
            end
            if (((w & a64ps_pkg::SUB_MASK) == a64ps_pkg::SUB_IMM ||
                 (w & a64ps_pkg::SUB_MASK) == a64ps_pkg::SUB_ALT) &&
                w[4:0] == a64ps_pkg::REG_SP)
            begin
                shifted   = 32'(w[21:10]) << (2 * w[23:22]);
                trk_frame = shifted[17:0];
            end
            if (w == a64ps_pkg::PAC_HINT_A || w == a64ps_pkg::PAC_HINT_B)
                trk_pac = 1'b1;
            if ((w & a64ps_pkg::BIMM_MASK) == a64ps_pkg::B_CODE ||
                (w & a64ps_pkg::BIMM_MASK) == a64ps_pkg::BL_CODE ||
                (w & a64ps_pkg::BREG_MASK) == a64ps_pkg::BR_CODE ||
                (w & a64ps_pkg::BREG_MASK) == a64ps_pkg::RET_CODE)
                trk_stop = 1'b1;
        end
        s     = '0;
        emits = last;
        if (last)
        begin
            s.fp_saved    = trk_fp;
            s.lr_saved    = trk_lr;
            s.pac_seen    = trk_pac;
            s.pair_total  = trk_pairs;
            s.list_count  = trk_count;
            s.frame_bytes = trk_frame;
            // slots past the count read as zero
            for (k = 0; k < a64ps_pkg::SLOTS; k++)
            begin
                if (k < trk_count)
                begin
                    if (k < 8)
                        s.list_low[5 * k +: 5] = trk_list[k];
                    else
                        s.list_high[5 * (k - 8) +: 5] = trk_list[k];
                end
            end
            clear_track();
        end
    endtask

    function automatic logic [31:0] make_word(word_kind_t kind);
        logic [31:0] r;
        logic [31:0] w;
        logic [31:0] cls;
        r = $urandom;
        w = r;
        case (kind)
            W_PAIR:
            begin
                cls = $urandom_range(0, 1) ? a64ps_pkg::STP_PREIDX : a64ps_pkg::STP_OFFSET;
                w   = {cls[31:22], r[21:0]};
                case ($urandom_range(0, 3))
                    0: w[4:0] = a64ps_pkg::REG_FP;
                    1: w[4:0] = a64ps_pkg::REG_LR;
                    default: ;
                endcase
                case ($urandom_range(0, 7))
                    0: w[14:10] = a64ps_pkg::REG_LR;
                    1: w[14:10] = a64ps_pkg::REG_FP;
                    2: w[14:10] = w[4:0];
                    default: ;
                endcase
            end
            W_SUB:
            begin
                cls = $urandom_range(0, 1) ? a64ps_pkg::SUB_ALT : a64ps_pkg::SUB_IMM;
                w   = {cls[31:23], r[22:0]};
                if ($urandom_range(0, 4) != 0)
                    w[4:0] = a64ps_pkg::REG_SP;
            end
            W_PAC:
                w = $urandom_range(0, 1) ? a64ps_pkg::PAC_HINT_B : a64ps_pkg::PAC_HINT_A;
            W_BRANCH:
            begin
                case ($urandom_range(0, 3))
                    0: w = {a64ps_pkg::B_CODE[31:26], r[25:0]};
                    1: w = {a64ps_pkg::BL_CODE[31:26], r[25:0]};
                    2: w = a64ps_pkg::BR_CODE | (32'(r[4:0]) << 5);
                    default: w = a64ps_pkg::RET_CODE | (32'(r[4:0]) << 5);
                endcase
            end
            W_NEAR:
            begin
                // one bit away from a decoded word
                case ($urandom_range(0, 3))
                    0: w = make_word(W_PAIR);
                    1: w = make_word(W_SUB);
                    2: w = make_word(W_PAC);
                    default: w = make_word(W_BRANCH);
                endcase
                w = w ^ (32'h1 << $urandom_range(0, 31));
            end
            default: ;
        endcase
        return w;
    endfunction

    function automatic word_kind_t pick_prologue_kind();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return W_PAIR;
        else if (r < 50)
            return W_SUB;
        else if (r < 58)
            return W_PAC;
        else if (r < 65)
            return W_BRANCH;
        else if (r < 75)
            return W_NEAR;
        return W_NOISE;
    endfunction

    // Offer one word; returns at the edge where it is taken.
    task automatic push_word(input logic [31:0] word, input logic last,
                             input bit typed, input a64ps_pkg::summary_t want);
        int unsigned         gap;
        a64ps_pkg::summary_t s;
        bit                  emits;
        gap = quiet ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent_words++;
        track_word(word, last, s, emits);
        if (emits)
            summary_q.push_back(typed ? want : s);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        a64ps_pkg::summary_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (summary_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected summary 0x%0h", m_tdata);
            end
            else
            begin
                want = summary_q.pop_front();
                check_field("frame_pointer_saved", 64'(want.fp_saved), 64'(m_tdata[0]));
                check_field("link_saved", 64'(want.lr_saved), 64'(m_tdata[1]));
                check_field("pac_seen", 64'(want.pac_seen), 64'(m_tdata[2]));
                check_field("pair_reg_total", 64'(want.pair_total), 64'(m_tdata[9:3]));
                check_field("list_count", 64'(want.list_count), 64'(m_tdata[14:10]));
                check_field("list_low_half", 64'(want.list_low), 64'(m_tdata[54:15]));
                check_field("list_high_half", 64'(want.list_high), 64'(m_tdata[94:55]));
                check_field("stack_frame_bytes", 64'(want.frame_bytes),
                            64'(m_tdata[112:95]));
                check_field("pad", 64'd0, 64'(m_tdata[119:113]));
            end
        end
    end

    // receiver: random stall before each summary, none while quiet
    initial
    begin
        int unsigned stall;
        m_tready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 7);
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    initial
    begin
        int unsigned seq_no;
        int unsigned seq_len;
        int unsigned shape;
        int unsigned i;
        bit          noisy;
        word_kind_t  kind;

        clk           = 1'b0;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tlast       = 1'b0;
        cycles        = 0;
        mismatches    = 0;
        sent_words    = 0;
        quiet         = 1'b0;
        seq_no        = 0;
        clear_track();

        // after reset, full prologue, scan stop, frame extremes, list overflow, branch kinds
        directed_rows.push_back('{32'h0000_0000, 1'b1, 1'b1, '0});
        directed_rows.push_back('{32'hd503_233f, 1'b0, 1'b0, '0});
        directed_rows.push_back('{32'ha9bf_7bfd, 1'b0, 1'b0, '0});
        directed_rows.push_back('{32'hd101_03ff, 1'b0, 1'b0, '0});
        directed_rows.push_back('{32'ha901_53f3, 1'b0, 1'b0, '0});
        directed_rows.push_back('{32'hd65f_03c0, 1'b0, 1'b0, '0});
        directed_rows.push_back('{32'ha9bf_7bfd, 1'b1, 1'b0, '0});
        directed_rows.push_back('{32'hd3ff_fc1f, 1'b1, 1'b1, MAX_FRAME_SUMMARY});
        directed_rows.push_back('{32'hd503_235f, 1'b0, 1'b0, '0});
        directed_rows.push_back('{32'ha940_7bfd, 1'b0, 1'b0, '0});
        directed_rows.push_back('{32'hd101_03e0, 1'b0, 1'b0, '0});
        directed_rows.push_back('{32'hd380_041f, 1'b0, 1'b0, '0});
        directed_rows.push_back('{32'h97ff_ffff, 1'b1, 1'b0, '0});
        directed_rows.push_back('{32'ha900_0000, 1'b0, 1'b0, '0});
        directed_rows.push_back('{32'ha900_7c1f, 1'b0, 1'b0, '0});
        directed_rows.push_back('{32'ha980_0801, 1'b0, 1'b0, '0});
        directed_rows.push_back('{32'ha900_1003, 1'b0, 1'b0, '0});
        directed_rows.push_back('{32'ha900_1805, 1'b0, 1'b0, '0});
        directed_rows.push_back('{32'ha900_2007, 1'b0, 1'b0, '0});
        directed_rows.push_back('{32'ha900_2809, 1'b0, 1'b0, '0});
        directed_rows.push_back('{32'ha900_300b, 1'b0, 1'b0, '0});
        directed_rows.push_back('{32'ha900_380d, 1'b0, 1'b0, '0});
        directed_rows.push_back('{32'ha900_7bde, 1'b0, 1'b0, '0});
        directed_rows.push_back('{32'ha900_400f, 1'b0, 1'b0, '0});
        directed_rows.push_back('{32'h17ff_ffff, 1'b1, 1'b0, '0});
        directed_rows.push_back('{32'hd61f_0220, 1'b1, 1'b1, '0});
        directed_rows.push_back('{32'hffff_ffff, 1'b1, 1'b1, '0});

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
            push_word(directed_rows[r].word, directed_rows[r].last,
                      directed_rows[r].typed, directed_rows[r].want);

        sent_words = 0;
        while (sent_words < RANDOM_WORDS)
        begin
            seq_no++;
            quiet = (seq_no % 32) >= 26;
            if (seq_no % 48 == 24)
            begin
                // hold off until every summary has drained
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (summary_q.size() != 0)
                    @(posedge clk);
            end
            shape = $urandom_range(0, 24);
            if (shape == 0)
                seq_len = $urandom_range(32, 36);
            else if (shape <= 2)
                seq_len = $urandom_range(30, 45);
            else
                seq_len = $urandom_range(1, 12);
            noisy = (shape >= 20);
            for (i = 0; i < seq_len; i++)
            begin
                if (shape == 0)
                    kind = W_PAIR;
                else if (noisy)
                    kind = $urandom_range(0, 1) ? W_NOISE : W_NEAR;
                else
                    kind = pick_prologue_kind();
                push_word(make_word(kind), i == seq_len - 1, 1'b0, '0);
            end
        end
        s_tvalid <= 1'b0;

        while (summary_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatches == 0 && summary_q.size() == 0)
            $display("a64_prologue_scanner test passed");
        else
            $display("a64_prologue_scanner test failed");
        $finish;
    end

endmodule

@@ files.f @@
design/a64ps_pkg.sv
design/a64ps_decode.sv
design/a64ps_frame.sv
design/a64_prologue_scanner.sv
tb/sv/tb_a64_prologue_scanner.sv
